// ===== sv/met_pkg.sv =====
// Shared types, constants and helpers for the multi-channel edge trigger.
// No dependencies; every other file in the project imports this package.
`default_nettype none

package met_pkg;

  localparam int MET_MAX_COND  = 8;
  localparam int MET_MAX_CHUNK = 65536;

  localparam int LEVEL_W   = 8;    // levels / present / enable_mask width
  localparam int MODE_W    = 16;   // edge_modes width
  localparam int WORD_W    = 16;   // 16-bit config and result fields
  localparam int TPOS_W    = 17;   // trigger_position width
  localparam int CFG_W     = 17;   // widest register
  localparam int CFG_IDX_W = 3;

  localparam logic [TPOS_W-1:0] TPOS_ONE   = 17'h10000;
  localparam logic [32:0]       ROUND_HALF = 33'd32768;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENABLE_MASK = 3'd0,
    REG_EDGE_MODES  = 3'd1,
    REG_COMBINE_AND = 3'd2,
    REG_COIN_WINDOW = 3'd3,
    REG_WINDOW_LEN  = 3'd4,
    REG_TRIG_POS    = 3'd5
  } cfg_reg_t;

  typedef enum logic [1:0] {
    EDGE_RISE = 2'd0,
    EDGE_FALL = 2'd1,
    EDGE_ANY  = 2'd2
  } edge_kind_t;

  // Register file plus the pre/post split derived from it.
  typedef struct packed {
    logic [LEVEL_W-1:0] enable_mask;
    logic [MODE_W-1:0]  edge_modes;
    logic               combine_and;
    logic [WORD_W-1:0]  coin_window;
    logic [WORD_W-1:0]  window_len;
    logic [TPOS_W-1:0]  trig_pos;
    logic [WORD_W-1:0]  pre;
    logic [WORD_W-1:0]  post;
  } met_cfg_t;

  function automatic logic edge_seen(input logic [1:0] kind, input logic prev_lvl,
                                     input logic now);
    logic hit;
    hit = 1'b0;
    case (kind)
      EDGE_RISE: hit = !prev_lvl && now;
      EDGE_FALL: hit = prev_lvl && !now;
      EDGE_ANY:  hit = prev_lvl != now;
      default:   hit = 1'b0;
    endcase
    return hit;
  endfunction

endpackage

`default_nettype wire

// ===== sv/met_cfg.sv =====
// Configuration registers and the registered pre/post split of the capture window.
// Depends on met_pkg.
`default_nettype none

module met_cfg import met_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  output met_cfg_t                  cfg
);

  logic [LEVEL_W-1:0] enable_mask_r;
  logic [MODE_W-1:0]  edge_modes_r;
  logic               combine_and_r;
  logic [WORD_W-1:0]  coin_window_r;
  logic [WORD_W-1:0]  window_len_r;
  logic [TPOS_W-1:0]  trig_pos_r;

  logic [32:0]        prod_r;
  logic [32:0]        prod_nxt;
  logic [WORD_W-1:0]  pre_r;
  logic [WORD_W-1:0]  pre_nxt;
  logic [WORD_W-1:0]  post_r;
  logic [WORD_W-1:0]  post_nxt;
  logic [TPOS_W-1:0]  tp_sat;
  logic [32:0]        rnd_sum;
  logic [16:0]        rnd;
  logic [16:0]        last_pos;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_mask_r <= '0;
      edge_modes_r  <= '0;
      combine_and_r <= 1'b0;
      coin_window_r <= '0;
      window_len_r  <= '0;
      trig_pos_r    <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_ENABLE_MASK: enable_mask_r <= cfg_data[LEVEL_W-1:0];
        REG_EDGE_MODES:  edge_modes_r  <= cfg_data[MODE_W-1:0];
        REG_COMBINE_AND: combine_and_r <= cfg_data[0];
        REG_COIN_WINDOW: coin_window_r <= cfg_data[WORD_W-1:0];
        REG_WINDOW_LEN:  window_len_r  <= cfg_data[WORD_W-1:0];
        REG_TRIG_POS:    trig_pos_r    <= cfg_data[TPOS_W-1:0];
        default: ;
      endcase
    end
  end

  // Product is registered; rounding and clamp work on the registered product.
  always_comb begin
    tp_sat   = (trig_pos_r > TPOS_ONE) ? TPOS_ONE : trig_pos_r;
    prod_nxt = 33'(tp_sat) * 33'(window_len_r);
    rnd_sum  = prod_r + ROUND_HALF;
    rnd      = rnd_sum[32:16];
    last_pos = 17'(window_len_r) - 17'd1;
    if (window_len_r == '0) begin
      pre_nxt = '0;
    end else if (rnd > last_pos) begin
      pre_nxt = last_pos[WORD_W-1:0];
    end else begin
      pre_nxt = rnd[WORD_W-1:0];
    end
    post_nxt = window_len_r - pre_nxt;
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    pre_r  <= pre_nxt;
    post_r <= post_nxt;
  end

  always_comb begin
    cfg.enable_mask = enable_mask_r;
    cfg.edge_modes  = edge_modes_r;
    cfg.combine_and = combine_and_r;
    cfg.coin_window = coin_window_r;
    cfg.window_len  = window_len_r;
    cfg.trig_pos    = trig_pos_r;
    cfg.pre         = pre_r;
    cfg.post        = post_r;
  end

endmodule

`default_nettype wire

// ===== sv/met_hit.sv =====
// Input register and per-condition edge tracking; hands a hit snapshot on at chunk end.
// Depends on met_pkg.
`default_nettype none

module met_hit import met_pkg::*; #(
  parameter int NUM_COND = MET_MAX_COND,
  parameter int IDX_W    = 16,
  parameter int MAX_CHUNK = MET_MAX_CHUNK
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  met_cfg_t                            cfg,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [LEVEL_W-1:0]             in_levels,
  input  wire logic [LEVEL_W-1:0]             in_present,
  input  wire logic                           in_last,
  output logic                                snap_valid,
  input  wire logic                           snap_ready,
  output logic [NUM_COND-1:0]                 snap_hv,
  output logic [NUM_COND-1:0][IDX_W-1:0]      snap_hidx,
  output logic [IDX_W:0]                      snap_cyc
);

  localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(MAX_CHUNK - 1);

  logic                           s0_v_r;
  logic [NUM_COND-1:0]            lv_r;
  logic [LEVEL_W-1:0]             pr_r;
  logic                           last_r;

  logic [NUM_COND-1:0]            prev_r;
  logic [NUM_COND-1:0]            hv_r;
  logic [NUM_COND-1:0][IDX_W-1:0] hidx_r;
  logic [IDX_W-1:0]               sidx_r;

  logic                           snap_v_r;
  logic [NUM_COND-1:0]            snap_hv_r;
  logic [NUM_COND-1:0][IDX_W-1:0] snap_hidx_r;
  logic [IDX_W:0]                 snap_cyc_r;

  logic                           in_xfer;
  logic                           go;
  logic [NUM_COND-1:0]            cur;
  logic [NUM_COND-1:0]            new_hit;
  logic [NUM_COND-1:0]            hv_upd;
  logic [NUM_COND-1:0][IDX_W-1:0] hidx_upd;
  logic [IDX_W:0]                 cyc_nxt;

  // A non-last sample only updates state; a last one needs the snapshot slot.
  assign go       = s0_v_r && (!last_r || !snap_v_r || snap_ready);
  assign in_ready = !s0_v_r || go;
  assign in_xfer  = in_valid && in_ready;

  always_comb begin
    cur = lv_r & pr_r[NUM_COND-1:0];
    for (int c = 0; c < NUM_COND; c++) begin
      new_hit[c] = (sidx_r != '0) && pr_r[c] && !hv_r[c] &&
                   edge_seen(cfg.edge_modes[2*c +: 2], prev_r[c], cur[c]);
      hidx_upd[c] = new_hit[c] ? sidx_r : hidx_r[c];
    end
    hv_upd  = hv_r | new_hit;
    cyc_nxt = ((pr_r & cfg.enable_mask) != '0) ? ({1'b0, sidx_r} + (IDX_W+1)'(1)) : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r   <= 1'b0;
      prev_r   <= '0;
      hv_r     <= '0;
      sidx_r   <= '0;
      snap_v_r <= 1'b0;
    end else begin
      if (in_xfer) begin
        s0_v_r <= 1'b1;
      end else if (go) begin
        s0_v_r <= 1'b0;
      end
      if (go) begin
        prev_r <= cur;
        if (last_r) begin
          hv_r   <= '0;
          sidx_r <= '0;
        end else begin
          hv_r <= hv_upd;
          if (sidx_r != IDX_MAX) begin
            sidx_r <= sidx_r + IDX_W'(1);
          end
        end
      end
      if (go && last_r) begin
        snap_v_r <= 1'b1;
      end else if (snap_ready) begin
        snap_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      lv_r   <= in_levels[NUM_COND-1:0];
      pr_r   <= in_present;
      last_r <= in_last;
    end
    if (go && !last_r) begin
      hidx_r <= hidx_upd;
    end
    if (go && last_r) begin
      snap_hv_r   <= hv_upd;
      snap_hidx_r <= hidx_upd;
      snap_cyc_r  <= cyc_nxt;
    end
  end

  assign snap_valid = snap_v_r;
  assign snap_hv    = snap_hv_r;
  assign snap_hidx  = snap_hidx_r;
  assign snap_cyc   = snap_cyc_r;

  a_idx_restart: assert property (@(posedge clk) disable iff (!rst_n)
    go && last_r |=> sidx_r == '0)
    else $error("sample index not restarted after chunk end");

  a_hits_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    go && !last_r |=> (hv_r & $past(hv_r)) == $past(hv_r))
    else $error("first hit lost inside a chunk");

  a_snap_hold: assert property (@(posedge clk) disable iff (!rst_n)
    snap_v_r && !snap_ready |=> snap_v_r && $stable(snap_cyc_r))
    else $error("snapshot dropped while stalled");

endmodule

`default_nettype wire

// ===== sv/met_comb.sv =====
// Combines recorded first hits with OR (earliest) or AND (all within window).
// Depends on met_pkg.
`default_nettype none

module met_comb import met_pkg::*; #(
  parameter int NUM_COND = MET_MAX_COND,
  parameter int IDX_W    = 16
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  met_cfg_t                       cfg,
  input  wire logic                      snap_valid,
  output logic                           snap_ready,
  input  wire logic [NUM_COND-1:0]       snap_hv,
  input  wire logic [NUM_COND-1:0][IDX_W-1:0] snap_hidx,
  input  wire logic [IDX_W:0]            snap_cyc,
  output logic                           comb_valid,
  input  wire logic                      comb_ready,
  output logic                           comb_have,
  output logic [IDX_W-1:0]               comb_fire_at,
  output logic [IDX_W:0]                 comb_cyc
);

  logic                v_r;
  logic                have_r;
  logic [IDX_W-1:0]    fire_at_r;
  logic [IDX_W:0]      cyc_r;

  logic [NUM_COND-1:0] enm;
  logic [NUM_COND-1:0] hit;
  logic [NUM_COND-1:0] miss;
  logic [IDX_W-1:0]    lo;
  logic [IDX_W-1:0]    hi;
  logic [IDX_W-1:0]    span;
  logic [WORD_W-1:0]   win;
  logic                have_and;
  logic                have_or;
  logic                have_nxt;
  logic                xfer;

  assign snap_ready = !v_r || comb_ready;
  assign xfer       = snap_valid && snap_ready;

  always_comb begin
    enm  = cfg.enable_mask[NUM_COND-1:0];
    hit  = enm & snap_hv;
    miss = enm & ~snap_hv;
    lo   = '1;
    hi   = '0;
    for (int c = 0; c < NUM_COND; c++) begin
      if (hit[c]) begin
        if (snap_hidx[c] < lo) lo = snap_hidx[c];
        if (snap_hidx[c] > hi) hi = snap_hidx[c];
      end
    end
    span     = hi - lo;
    win      = (cfg.coin_window == '0) ? WORD_W'(1) : cfg.coin_window;
    have_or  = hit != '0;
    have_and = (miss == '0) && (17'(span) < 17'(win));
    have_nxt = (enm != '0) && (cfg.combine_and ? have_and : have_or);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (xfer) begin
      v_r <= 1'b1;
    end else if (comb_ready) begin
      v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (xfer) begin
      have_r    <= have_nxt;
      fire_at_r <= lo;
      cyc_r     <= snap_cyc;
    end
  end

  assign comb_valid   = v_r;
  assign comb_have    = have_r;
  assign comb_fire_at = fire_at_r;
  assign comb_cyc     = cyc_r;

endmodule

`default_nettype wire

// ===== sv/met_hold.sv =====
// Fire placement by the pre/post split, holdoff tracking and the result register.
// Depends on met_pkg.
`default_nettype none

module met_hold import met_pkg::*; #(
  parameter int IDX_W = 16
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  met_cfg_t               cfg,
  input  wire logic              comb_valid,
  output logic                   comb_ready,
  input  wire logic              comb_have,
  input  wire logic [IDX_W-1:0]  comb_fire_at,
  input  wire logic [IDX_W:0]    comb_cyc,
  output logic                   res_valid,
  input  wire logic              res_ready,
  output logic                   res_fired,
  output logic [WORD_W-1:0]      res_index,
  output logic [WORD_W-1:0]      res_extra
);

  logic              hold_r;
  logic              hold_nxt;
  logic [WORD_W-1:0] prem_r;
  logic [WORD_W-1:0] prem_nxt;
  logic              out_v_r;
  logic              fired_r;
  logic              fired_nxt;
  logic [WORD_W-1:0] index_r;
  logic [WORD_W-1:0] index_nxt;
  logic [WORD_W-1:0] extra_r;
  logic [WORD_W-1:0] extra_nxt;

  logic              xfer;
  logic              win_off;
  logic [16:0]       cyc17;
  logic [16:0]       fire17;
  logic [16:0]       avail;

  assign comb_ready = !out_v_r || res_ready;
  assign xfer       = comb_valid && comb_ready;

  always_comb begin
    win_off   = cfg.window_len == '0;
    cyc17     = 17'(comb_cyc);
    fire17    = 17'(comb_fire_at);
    avail     = (cyc17 > fire17) ? cyc17 - fire17 : '0;
    hold_nxt  = 1'b0;
    prem_nxt  = prem_r;
    fired_nxt = 1'b0;
    index_nxt = '0;
    extra_nxt = '0;
    if (hold_r && !win_off) begin
      // Count post-trigger samples still owed by the latched fire.
      if (cyc17 >= 17'(prem_r)) begin
        fired_nxt = 1'b1;
        index_nxt = cfg.pre;
        extra_nxt = WORD_W'(cyc17 - 17'(prem_r));
        prem_nxt  = '0;
      end else begin
        hold_nxt = 1'b1;
        prem_nxt = prem_r - WORD_W'(cyc17);
      end
    end else if (comb_have) begin
      if (win_off) begin
        fired_nxt = 1'b1;
        index_nxt = WORD_W'(comb_fire_at);
      end else if (avail >= 17'(cfg.post)) begin
        fired_nxt = 1'b1;
        index_nxt = cfg.pre;
        extra_nxt = WORD_W'(avail - 17'(cfg.post));
      end else begin
        hold_nxt = 1'b1;
        prem_nxt = cfg.post - WORD_W'(avail);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_r  <= 1'b0;
      prem_r  <= '0;
      out_v_r <= 1'b0;
    end else begin
      if (xfer) begin
        hold_r  <= hold_nxt;
        prem_r  <= prem_nxt;
        out_v_r <= 1'b1;
      end else if (res_ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (xfer) begin
      fired_r <= fired_nxt;
      index_r <= index_nxt;
      extra_r <= extra_nxt;
    end
  end

  assign res_valid = out_v_r;
  assign res_fired = fired_r;
  assign res_index = index_r;
  assign res_extra = extra_r;

  a_hold_owes: assert property (@(posedge clk) disable iff (!rst_n)
    hold_r |-> prem_r != '0)
    else $error("holdoff latched with nothing owed");

  a_skip_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && !fired_r |-> index_r == '0 && extra_r == '0)
    else $error("skipped chunk carries nonzero fields");

  a_fire_clears: assert property (@(posedge clk) disable iff (!rst_n)
    xfer && fired_nxt |=> !hold_r)
    else $error("holdoff still set after a fire");

endmodule

`default_nettype wire

// ===== sv/multi_channel_edge_trigger.sv =====
// Multi-channel edge trigger with holdoff: takes one sample time per transfer.
// Throughput: one input transfer per cycle unless stalled: a chunk's last sample
// waits for the hit snapshot slot. From that transfer to out_tvalid the result
// passes the input reg (loaded on the transfer edge), hit snapshot, combine, result reg.
// The pre/post split follows a register write via the registered product, then rounding.
// rst_n (synchronous, active low) clears registers, hit state, holdoff and valids.
`default_nettype none

module multi_channel_edge_trigger import met_pkg::*; #(
  parameter int MAX_CONDITIONS = MET_MAX_COND,
  parameter int MAX_CHUNK      = MET_MAX_CHUNK
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  input  wire logic [15:0]          in_tdata,   // [7:0] levels, [15:8] present
  input  wire logic                 in_tlast,   // chunk_last
  output logic                      out_tvalid,
  input  wire logic                 out_tready,
  output logic [31:0]               out_tdata,  // [15:0] fire_index, [31:16] extra_samples
  output logic                      out_tuser   // fired
);

  localparam int NUM_COND = (MAX_CONDITIONS < LEVEL_W) ? MAX_CONDITIONS : LEVEL_W;
  localparam int IDX_W    = (MAX_CHUNK > 1) ? $clog2(MAX_CHUNK) : 1;

  met_cfg_t                       cfg;
  logic                           snap_valid;
  logic                           snap_ready;
  logic [NUM_COND-1:0]            snap_hv;
  logic [NUM_COND-1:0][IDX_W-1:0] snap_hidx;
  logic [IDX_W:0]                 snap_cyc;
  logic                           comb_valid;
  logic                           comb_ready;
  logic                           comb_have;
  logic [IDX_W-1:0]               comb_fire_at;
  logic [IDX_W:0]                 comb_cyc;
  logic                           res_fired;
  logic [WORD_W-1:0]              res_index;
  logic [WORD_W-1:0]              res_extra;

  met_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  met_hit #(
    .NUM_COND  (NUM_COND),
    .IDX_W     (IDX_W),
    .MAX_CHUNK (MAX_CHUNK)
  ) u_hit (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_levels  (in_tdata[7:0]),
    .in_present (in_tdata[15:8]),
    .in_last    (in_tlast),
    .snap_valid (snap_valid),
    .snap_ready (snap_ready),
    .snap_hv    (snap_hv),
    .snap_hidx  (snap_hidx),
    .snap_cyc   (snap_cyc)
  );

  met_comb #(
    .NUM_COND (NUM_COND),
    .IDX_W    (IDX_W)
  ) u_comb (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg),
    .snap_valid   (snap_valid),
    .snap_ready   (snap_ready),
    .snap_hv      (snap_hv),
    .snap_hidx    (snap_hidx),
    .snap_cyc     (snap_cyc),
    .comb_valid   (comb_valid),
    .comb_ready   (comb_ready),
    .comb_have    (comb_have),
    .comb_fire_at (comb_fire_at),
    .comb_cyc     (comb_cyc)
  );

  met_hold #(
    .IDX_W (IDX_W)
  ) u_hold (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg),
    .comb_valid   (comb_valid),
    .comb_ready   (comb_ready),
    .comb_have    (comb_have),
    .comb_fire_at (comb_fire_at),
    .comb_cyc     (comb_cyc),
    .res_valid    (out_tvalid),
    .res_ready    (out_tready),
    .res_fired    (res_fired),
    .res_index    (res_index),
    .res_extra    (res_extra)
  );

  assign out_tdata = {res_extra, res_index};
  assign out_tuser = res_fired;

endmodule

`default_nettype wire

// ===== sim/met_checker.sv =====
// Scoreboard for the multi-channel edge trigger: tracks register writes, predicts
// the per-chunk verdict from accepted samples and compares each result transfer.
// Depends on met_pkg for widths, register indexes and edge kinds.
module met_checker import met_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_tvalid,
  input  logic                 in_tready,
  input  logic [15:0]          in_tdata,   // [7:0] levels, [15:8] present
  input  logic                 in_tlast,   // chunk_last
  input  logic                 out_tvalid,
  input  logic                 out_tready,
  input  logic [31:0]          out_tdata,  // [15:0] fire_index, [31:16] extra_samples
  input  logic                 out_tuser,  // fired
  output int                   error_count,
  output int                   results_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic              fired;
    logic [WORD_W-1:0] fire_index;
    logic [WORD_W-1:0] extra;
  } trig_verdict_t;

  trig_verdict_t chunk_verdicts[$];
  int            verdicts_checked;

  // shadow register file
  logic [LEVEL_W-1:0] enable_mask;
  logic [MODE_W-1:0]  edge_modes;
  logic               combine_and;
  logic [WORD_W-1:0]  coin_window;
  logic [WORD_W-1:0]  window_len;
  logic [TPOS_W-1:0]  trig_pos;

  // trigger state
  logic [LEVEL_W-1:0]      prev_levels;
  logic [MET_MAX_COND-1:0] hit_valid;
  logic [WORD_W-1:0]       hit_index [MET_MAX_COND];
  logic [WORD_W-1:0]       sample_idx;
  logic                    holdoff;
  logic [16:0]             post_left;

  initial begin
    error_count     = 0;
    results_pending = 0;
  end

  task automatic report(input string msg);
    error_count++;
    if (error_count <= 40) $display("%0t ns: mismatch: %s", $realtime, msg);
  endtask

  // Advance the trigger by one sample; returns 1 with the verdict when the chunk closes.
  function automatic bit trigger_step(input logic [LEVEL_W-1:0] lv,
                                      input logic [LEVEL_W-1:0] pr,
                                      input logic lst, output trig_verdict_t res);
    logic [LEVEL_W-1:0] cur;
    logic               lvl_was, lvl_now, hit;
    longint unsigned    len, tp, pre, post, cyc, avail, fire_at, lo, hi, spread_lim;
    int                 n_en, c;
    bit                 have, all_hit;
    cur = lv & pr;
    res = '0;
    if (sample_idx != 0) begin
      for (c = 0; c < MET_MAX_COND; c++) begin
        lvl_was = prev_levels[c];
        lvl_now = cur[c];
        case (edge_kind_t'(edge_modes[2*c +: 2]))
          EDGE_RISE: hit = !lvl_was && lvl_now;
          EDGE_FALL: hit = lvl_was && !lvl_now;
          EDGE_ANY:  hit = lvl_was ^ lvl_now;
          default:   hit = 1'b0;
        endcase
        if (pr[c] && !hit_valid[c] && hit) begin
          hit_valid[c] = 1'b1;
          hit_index[c] = sample_idx;
        end
      end
    end
    prev_levels = cur;
    if (!lst) begin
      if (sample_idx != 16'hFFFF) sample_idx++;
      return 1'b0;
    end

    len  = 64'(window_len);
    tp   = (trig_pos > TPOS_ONE) ? 64'(TPOS_ONE) : 64'(trig_pos);
    pre  = '0;
    post = '0;
    if (len != 0) begin
      pre = (tp * len + 64'd32768) >> 16;
      if (pre > len - 64'd1) pre = len - 64'd1;
      post = len - pre;
    end
    cyc = ((pr & enable_mask) != 0) ? 64'(sample_idx) + 64'd1 : 64'd0;

    // a disabled window releases a pending holdoff and the chunk is judged afresh
    if (holdoff && len == 0) holdoff = 1'b0;

    if (holdoff) begin
      if (cyc >= post_left) begin
        res       = '{1'b1, WORD_W'(pre), WORD_W'(cyc - post_left)};
        holdoff   = 1'b0;
        post_left = '0;
      end else begin
        post_left = 17'(post_left - cyc);
      end
    end else begin
      n_en    = 0;
      have    = 1'b0;
      all_hit = 1'b1;
      fire_at = '0;
      lo      = '1;
      hi      = '0;
      for (c = 0; c < MET_MAX_COND; c++) begin
        if (!enable_mask[c]) continue;
        n_en++;
        if (!hit_valid[c]) begin
          all_hit = 1'b0;
          continue;
        end
        if (!have || 64'(hit_index[c]) < fire_at) fire_at = 64'(hit_index[c]);
        have = 1'b1;
        if (64'(hit_index[c]) < lo) lo = 64'(hit_index[c]);
        if (64'(hit_index[c]) > hi) hi = 64'(hit_index[c]);
      end
      if (combine_and && n_en > 0) begin
        spread_lim = (coin_window == 0) ? 64'd1 : 64'(coin_window);
        have       = all_hit && (hi - lo) < spread_lim;
        fire_at    = lo;
      end
      if (n_en != 0 && have) begin
        if (len == 0) begin
          res = '{1'b1, WORD_W'(fire_at), WORD_W'(0)};
        end else begin
          avail = (cyc > fire_at) ? cyc - fire_at : 64'd0;
          if (avail >= post) begin
            res = '{1'b1, WORD_W'(pre), WORD_W'(avail - post)};
          end else begin
            holdoff   = 1'b1;
            post_left = 17'(post - avail);
          end
        end
      end
    end

    hit_valid  = '0;
    for (c = 0; c < MET_MAX_COND; c++) hit_index[c] = '0;
    sample_idx = '0;
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    trig_verdict_t got, want, pred;
    if (!rst_n) begin
      enable_mask = '0;
      edge_modes  = '0;
      combine_and = 1'b0;
      coin_window = '0;
      window_len  = '0;
      trig_pos    = '0;
      prev_levels = '0;
      hit_valid   = '0;
      for (int c = 0; c < MET_MAX_COND; c++) hit_index[c] = '0;
      sample_idx  = '0;
      holdoff     = 1'b0;
      post_left   = '0;
      chunk_verdicts.delete();
    end else begin
      // compare first so a stray result never pairs with a verdict made this edge
      if (out_tvalid && out_tready) begin
        got = '{out_tuser, out_tdata[15:0], out_tdata[31:16]};
        if (chunk_verdicts.size() == 0) begin
          report($sformatf("result transfer with no chunk pending (fired=%0d idx=%0d extra=%0d)",
                           got.fired, got.fire_index, got.extra));
        end else begin
          want = chunk_verdicts.pop_front();
          if (got.fired !== want.fired)
            report($sformatf("chunk %0d fired: got %0d, want %0d",
                             verdicts_checked, got.fired, want.fired));
          if (got.fire_index !== want.fire_index)
            report($sformatf("chunk %0d fire_index: got %0d, want %0d",
                             verdicts_checked, got.fire_index, want.fire_index));
          if (got.extra !== want.extra)
            report($sformatf("chunk %0d extra_samples: got %0d, want %0d",
                             verdicts_checked, got.extra, want.extra));
          verdicts_checked++;
        end
      end
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_ENABLE_MASK: enable_mask = cfg_data[LEVEL_W-1:0];
          REG_EDGE_MODES:  edge_modes  = cfg_data[MODE_W-1:0];
          REG_COMBINE_AND: combine_and = cfg_data[0];
          REG_COIN_WINDOW: coin_window = cfg_data[WORD_W-1:0];
          REG_WINDOW_LEN:  window_len  = cfg_data[WORD_W-1:0];
          REG_TRIG_POS:    trig_pos    = cfg_data[TPOS_W-1:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        if (trigger_step(in_tdata[7:0], in_tdata[15:8], in_tlast, pred))
          chunk_verdicts.push_back(pred);
      end
    end
    results_pending <= chunk_verdicts.size();
  end

endmodule

// ===== sim/tb_multi_channel_edge_trigger.sv =====
// Top of the edge trigger testbench: clock, reset, register setup, sample stimulus
// with random gaps and output stalls, and the final verdict.
// Depends on met_pkg, multi_channel_edge_trigger and met_checker.
module tb_multi_channel_edge_trigger;
  timeunit 1ns;
  timeprecision 1ps;
  import met_pkg::*;

  localparam logic [1:0] EDGE_DEAD = 2'd3;   // edge kind that never triggers

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [15:0]          in_tdata = '0;   // [7:0] levels, [15:8] present
  logic                 in_tlast = 1'b0; // chunk_last
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [31:0]          out_tdata;       // [15:0] fire_index, [31:16] extra_samples
  logic                 out_tuser;       // fired
  int                   error_count;
  int                   results_pending;

  logic [7:0] active_mask = '0;
  int         tx_odds = 0;    // one gap in tx_odds samples; 0 means none
  int         rx_odds = 0;
  bit         quiet = 1'b0;   // no idling on either side
  int         rx_stall_left = 0;
  int         samples_sent;

  multi_channel_edge_trigger dut (.*);
  met_checker checker_i (.*);

  always #10 clk = ~clk;

  always @(posedge clk) begin
    if (rx_stall_left > 0) begin
      rx_stall_left <= rx_stall_left - 1;
      out_tready    <= 1'b0;
    end else if (!quiet && rx_odds != 0 && $urandom_range(1, rx_odds) == 1) begin
      rx_stall_left <= $urandom_range(0, 5);
      out_tready    <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  task automatic send_sample(input logic [7:0] lv, input logic [7:0] pr, input logic lst);
    if (!quiet && tx_odds != 0 && $urandom_range(1, tx_odds) == 1) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {pr, lv};
    in_tlast  <= lst;
    do @(posedge clk); while (!in_tready);
  endtask

  // Hold the sender until every pending chunk verdict has been seen.
  task automatic await_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (results_pending != 0);
  endtask

  task automatic put_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  task automatic write_regs(input logic [7:0] en, input logic [15:0] modes, input logic comb,
                            input logic [15:0] coin, input logic [15:0] wlen,
                            input logic [16:0] tpos);
    await_results();
    repeat (8) @(posedge clk);
    put_reg(REG_ENABLE_MASK, CFG_W'(en));
    put_reg(REG_EDGE_MODES, CFG_W'(modes));
    put_reg(REG_COMBINE_AND, CFG_W'(comb));
    put_reg(REG_COIN_WINDOW, CFG_W'(coin));
    put_reg(REG_WINDOW_LEN, CFG_W'(wlen));
    put_reg(REG_TRIG_POS, CFG_W'(tpos));
    cfg_wr_en   <= 1'b0;
    active_mask = en;
  endtask

  task automatic random_config();
    logic [7:0]  en;
    logic [15:0] modes, coin, wlen;
    logic [16:0] tpos;
    case ($urandom_range(0, 4))
      0:       en = 8'hFF;
      1:       en = 8'h01 << $urandom_range(0, 7);
      2:       en = '0;
      default: en = 8'($urandom);
    endcase
    modes = ($urandom_range(0, 3) == 0) ? {8{EDGE_ANY}} : 16'($urandom);
    case ($urandom_range(0, 4))
      0:       coin = '0;
      1:       coin = 16'd1;
      2:       coin = 16'hFFFF;
      3:       coin = 16'($urandom);
      default: coin = 16'($urandom_range(2, 6));
    endcase
    case ($urandom_range(0, 11))
      0, 1, 2: wlen = '0;
      3:       wlen = 16'hFFFF;
      4:       wlen = 16'($urandom);
      5:       wlen = 16'd1;
      default: wlen = 16'($urandom_range(2, 24));
    endcase
    case ($urandom_range(0, 4))
      0:       tpos = '0;
      1:       tpos = TPOS_ONE;
      2:       tpos = 17'h1FFFF;
      3:       tpos = 17'($urandom);
      default: tpos = 17'($urandom_range(0, 65536));
    endcase
    write_regs(en, modes, 1'($urandom), coin, wlen, tpos);
  endtask

  // Mostly well-formed chunks: enabled streams present, levels toggling together or apart.
  task automatic send_chunk(input int len, input bit noisy);
    logic [7:0] lv, pr;
    int         i;
    lv = 8'($urandom);
    for (i = 0; i < len; i++) begin
      case ($urandom_range(0, 3))
        0:       lv = ~lv;
        1:       lv = lv ^ 8'($urandom & $urandom);
        default: ;
      endcase
      pr = noisy ? 8'($urandom) : active_mask | 8'($urandom & $urandom & $urandom);
      if (!noisy && $urandom_range(0, 11) == 0) pr = pr ^ (8'h01 << $urandom_range(0, 7));
      send_sample(lv, pr, i == len - 1);
    end
  endtask

  initial begin
    int len;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // registers at reset: nothing enabled, chunk is skipped
    send_sample(8'hFF, 8'hFF, 1'b0);
    send_sample(8'h00, 8'hFF, 1'b1);

    // OR, window off, every edge kind including the dead code; absent previous sample
    write_regs(8'hFF, {EDGE_DEAD, EDGE_ANY, EDGE_FALL, EDGE_RISE,
                       EDGE_DEAD, EDGE_ANY, EDGE_FALL, EDGE_RISE}, 1'b0, '0, '0, '0);
    send_sample(8'h00, 8'hFF, 1'b0);
    send_sample(8'hFF, 8'hFF, 1'b0);
    send_sample(8'h00, 8'hFF, 1'b0);
    send_sample(8'hFF, 8'h0F, 1'b0);
    send_sample(8'h00, 8'hFF, 1'b1);
    send_sample(8'hFF, 8'hFF, 1'b1);   // single-sample chunk

    // AND with zero coincidence window, trigger position of exactly one
    write_regs(8'h0F, {8{EDGE_ANY}}, 1'b1, '0, 16'd8, TPOS_ONE);
    send_sample(8'h00, 8'hFF, 1'b0);
    send_sample(8'h0F, 8'hFF, 1'b0);
    send_sample(8'h0F, 8'hFF, 1'b1);

    // position above one saturates
    write_regs(8'h01, {8{EDGE_RISE}}, 1'b0, 16'hFFFF, 16'd16, 17'h1FFFF);
    send_sample(8'h00, 8'h01, 1'b0);
    send_sample(8'h01, 8'h01, 1'b1);
    // short post-trigger tail latches a holdoff, then counts it down
    write_regs(8'h01, {8{EDGE_RISE}}, 1'b0, 16'hFFFF, 16'd16, '0);
    send_sample(8'h00, 8'h01, 1'b0);
    send_sample(8'h01, 8'h01, 1'b1);
    send_sample(8'h00, 8'h01, 1'b0);
    send_sample(8'h00, 8'h00, 1'b1);   // enabled stream absent at the end
    send_sample(8'h00, 8'h01, 1'b0);
    send_sample(8'h01, 8'h01, 1'b1);
    // disabling the window drops the holdoff
    write_regs(8'h01, {8{EDGE_RISE}}, 1'b0, 16'hFFFF, '0, '0);
    send_sample(8'h00, 8'h01, 1'b0);
    send_sample(8'h01, 8'h01, 1'b1);

    samples_sent = 0;
    while (samples_sent < 450) begin
      random_config();
      case ($urandom_range(0, 2))
        0:       tx_odds = 0;
        1:       tx_odds = 3;
        default: tx_odds = 8;
      endcase
      case ($urandom_range(0, 2))
        0:       rx_odds = 0;
        1:       rx_odds = 2;
        default: rx_odds = 6;
      endcase
      repeat ($urandom_range(3, 8)) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 60) : $urandom_range(1, 12);
        send_chunk(len, $urandom_range(0, 5) == 0);
        samples_sent += len;
        if (samples_sent >= 390) quiet = 1'b1;
        if ($urandom_range(0, 5) == 0) await_results();
      end
    end

    await_results();
    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("timeout: results still outstanding");
    $display("DONE: errors detected");
    $finish;
  end

endmodule
